[sv/uer_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package uer_pkg;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_CHARGING = 2'd1,
    PH_RELEASED = 2'd2,
    PH_RUNNING  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    C_IDLE = 2'd0,
    C_EVAL = 2'd1,
    C_DIV  = 2'd2,
    C_DONE = 2'd3
  } ctrl_state_e;

  localparam logic       KIND_POLL   = 1'b0;
  localparam logic       KIND_ECHO   = 1'b1;
  localparam logic [7:0] InchDiv     = 8'd148;
  localparam logic [7:0] MaxInches   = 8'd150;
  localparam logic [7:0] OutOfRange  = 8'd255;
  localparam logic [7:0] TpmReset    = 8'd16;
  localparam int         DvsrBits    = 16;

  typedef struct packed {
    logic load;
    logic div_init;
    logic div_step;
    logic commit;
  } uer_cmd_t;

  typedef struct packed {
    logic measure;
    logic div_last;
  } uer_sts_t;

endpackage

`default_nettype wire

[sv/uer_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module uer_ctrl import uer_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  wire      out_ready_i,
  input  uer_sts_t sts_i,
  output uer_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= C_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      C_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = C_EVAL;
        end
      end
      C_EVAL: begin
        if (sts_i.measure) begin
          cmd_o.div_init = 1'b1;
          state_d        = C_DIV;
        end else begin
          state_d = C_DONE;
        end
      end
      C_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = C_DONE;
        end
      end
      C_DONE: begin
        // result register is shared by all items; wait for it to drain
        if (out_free) begin
          cmd_o.commit = 1'b1;
          out_valid_d  = 1'b1;
          state_d      = C_IDLE;
        end
      end
      default: state_d = C_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;

  a_commit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.commit |=> out_valid_q)
    else $error("commit did not raise out_valid");

  a_div_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == C_DIV && !sts_i.div_last) |=> state_q == C_DIV)
    else $error("divide left early");

  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == C_EVAL && !in_ready_o))
    else $error("accepted beat not evaluated");

endmodule

`default_nettype wire

[sv/uer_dp.sv]
`timescale 1ns / 1ps
`default_nettype none

module uer_dp import uer_pkg::*; #(
  parameter int CAPTURE_BITS = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        kind_i,
  input  wire [31:0] capture_time_i,
  input  wire        cfg_we_i,
  input  wire [7:0]  cfg_data_i,
  input  uer_cmd_t   cmd_i,
  output uer_sts_t   sts_o,
  output logic       trigger_level_o,
  output logic [7:0] distance_inches_o,
  output logic       new_reading_o,
  output logic [1:0] phase_o
);

  localparam int CntBits = $clog2(CAPTURE_BITS);

  logic [7:0]              tpm_q;
  logic                    kind_q;
  logic [CAPTURE_BITS-1:0] num_q, num_d;
  logic [DvsrBits-1:0]     rem_q, rem_d;
  logic [DvsrBits-1:0]     dvsr_q;
  logic [CntBits-1:0]      cnt_q;
  phase_e                  phase_q, phase_d;
  logic                    trig_q, trig_d;
  logic [7:0]              dist_q, dist_d;
  logic                    ign_q, ign_d;
  logic                    fresh_q, fresh_d;

  logic [7:0]          tpm_eff;
  logic [DvsrBits:0]   rem_sh;
  logic                ge;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= TpmReset;
    end else if (cfg_we_i) begin
      tpm_q <= cfg_data_i;
    end
  end

  // floor(floor(t/a)/b) == floor(t/(a*b)), so one divide by tpm*148
  assign tpm_eff = (tpm_q == 8'd0) ? 8'd1 : tpm_q;
  assign rem_sh  = {rem_q, num_q[CAPTURE_BITS-1]};
  assign ge      = rem_sh >= {1'b0, dvsr_q};

  always_comb begin
    rem_d = ge ? DvsrBits'(rem_sh - {1'b0, dvsr_q}) : rem_sh[DvsrBits-1:0];
    num_d = {num_q[CAPTURE_BITS-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      num_q  <= capture_time_i[CAPTURE_BITS-1:0];
    end else if (cmd_i.div_step) begin
      num_q <= num_d;
      rem_q <= rem_d;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.div_init) begin
      rem_q  <= '0;
      dvsr_q <= DvsrBits'(tpm_eff) * DvsrBits'(InchDiv);
      cnt_q  <= CntBits'(CAPTURE_BITS - 1);
    end
  end

  assign sts_o.measure  = (kind_q == KIND_ECHO) && (phase_q == PH_RUNNING);
  assign sts_o.div_last = (cnt_q == '0);

  always_comb begin
    phase_d = phase_q;
    trig_d  = trig_q;
    dist_d  = dist_q;
    ign_d   = ign_q;
    fresh_d = 1'b0;
    if (kind_q == KIND_POLL) begin
      case (phase_q)
        PH_IDLE: begin
          trig_d  = 1'b1;
          phase_d = PH_CHARGING;
        end
        PH_CHARGING: begin
          trig_d  = 1'b0;
          phase_d = PH_RELEASED;
        end
        default: ;
      endcase
    end else begin
      case (phase_q)
        PH_RELEASED: phase_d = PH_RUNNING;
        PH_RUNNING: begin
          fresh_d = 1'b1;
          phase_d = PH_IDLE;
          if (num_q > CAPTURE_BITS'(MaxInches)) begin
            dist_d = OutOfRange;
            ign_d  = 1'b1;
          end else if (ign_q) begin
            // reading right after an out-of-range one is discarded
            dist_d = OutOfRange;
            ign_d  = 1'b0;
          end else begin
            dist_d = num_q[7:0];
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      trig_q  <= 1'b0;
      dist_q  <= 8'd0;
      ign_q   <= 1'b0;
      fresh_q <= 1'b0;
    end else if (cmd_i.commit) begin
      phase_q <= phase_d;
      trig_q  <= trig_d;
      dist_q  <= dist_d;
      ign_q   <= ign_d;
      fresh_q <= fresh_d;
    end
  end

  assign trigger_level_o   = trig_q;
  assign distance_inches_o = dist_q;
  assign new_reading_o     = fresh_q;
  assign phase_o           = phase_q;

  a_trig_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    trig_q == (phase_q == PH_CHARGING))
    else $error("trigger level out of step with phase");

  a_fresh_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q |-> phase_q == PH_IDLE)
    else $error("new reading outside idle");

  a_dist_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dist_q <= MaxInches) || (dist_q == OutOfRange))
    else $error("distance out of range");

endmodule

`default_nettype wire

[sv/ultrasonic_echo_ranger.sv]
// Ultrasonic echo ranger: trigger sequencing and echo-to-inches conversion
// for one sensor (instantiate twice for two sensors).
// Input channel (in_valid_i/in_ready_o): one beat per event, kind_i = 0 for
// a poll tick, 1 for an echo edge; capture_time_i is used on the completing echo edge.
// Output channel (out_valid_o/out_ready_i): exactly one beat per input beat,
// carrying trigger level, stored distance, new-reading flag and phase.
// Config channel (cfg_valid_i/cfg_ready_o): writes ticks_per_microsecond;
// always ready, write only while no item is in flight.
// Sequencing: a poll tick or any other echo edge passes through the evaluate
// and done states; the completing echo edge also runs the
// one-bit-per-cycle restoring divider (divisor ticks_per_microsecond * 148).
// Items are handled one at a time; the next can be accepted in the same
// cycle that the result appears in the output register.
// Reset: idle phase, trigger low, distance 0, config 16, no output pending.
// Output stall: the result register holds; one further item is accepted and
// processed, then waits until the pending beat is taken.
`timescale 1ns / 1ps
`default_nettype none

module ultrasonic_echo_ranger import uer_pkg::*; #(
  parameter int CAPTURE_BITS = 32
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        in_valid_i,
  output logic       in_ready_o,
  input  wire        kind_i,
  input  wire [31:0] capture_time_i,
  output logic       out_valid_o,
  input  wire        out_ready_i,
  output logic       trigger_level_o,
  output logic [7:0] distance_inches_o,
  output logic       new_reading_o,
  output logic [1:0] phase_o,
  input  wire        cfg_valid_i,
  output logic       cfg_ready_o,
  input  wire [7:0]  cfg_data_i
);

  uer_cmd_t cmd;
  uer_sts_t sts;

  assign cfg_ready_o = 1'b1;

  uer_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  uer_dp #(
    .CAPTURE_BITS (CAPTURE_BITS)
  ) u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .kind_i            (kind_i),
    .capture_time_i    (capture_time_i),
    .cfg_we_i          (cfg_valid_i && cfg_ready_o),
    .cfg_data_i        (cfg_data_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .trigger_level_o   (trigger_level_o),
    .distance_inches_o (distance_inches_o),
    .new_reading_o     (new_reading_o),
    .phase_o           (phase_o)
  );

endmodule

`default_nettype wire
